[rtl/core/assert_macros.svh]
// Assertion macros shared by the histogram mode subtraction RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/hms_pkg.sv]
// Package for the histogram mode subtraction block: widths, codes and
// the structs passed between the controller and the bin divider. No dependencies.
`timescale 1ns / 1ps

package hms_pkg;

    localparam int PIX_W          = 32;
    localparam int DIM_W          = 11;
    localparam int DIM_MAX        = 1024;
    localparam int CNT_W          = 21;
    localparam int NUM_BINS       = 256;
    localparam int BIN_W          = $clog2(NUM_BINS);
    localparam int MAX_PIXELS_DEF = 1048576;
    localparam int CFG_IDX_W      = 1;

    // floor(d/10) for d <= 1024 as (d * 6554) >> 16
    localparam int DIV10_MUL   = 6554;
    localparam int DIV10_SHIFT = 16;
    localparam int DIV10_PW    = DIM_W + 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_DRAIN   = 1'b1;
    localparam logic KIND_MODE  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef struct packed {
        logic             start;
        logic [PIX_W-1:0] dividend;
        logic [PIX_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [BIN_W-1:0] bin;
    } div_rsp_t;

endpackage

[rtl/core/hms_if.sv]
// Valid/ready channel interfaces for input items and result items.
// Depends on hms_pkg for the payload widths.
`timescale 1ns / 1ps

interface hms_item_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic signed [hms_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output operation, output pixel, input ready);
    modport sink   (input valid, input operation, input pixel, output ready);
endinterface

interface hms_result_if;
    logic                           valid;
    logic                           ready;
    logic signed [hms_pkg::PIX_W-1:0] value;
    logic                           kind;
    logic                           last;

    modport source (output valid, output value, output kind, output last, input ready);
    modport sink   (input valid, input value, input kind, input last, output ready);
endinterface

[rtl/core/hms_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/hms_bin_div.sv]
// Bin index unit: floor(NUM_BINS * d / r) clamped to NUM_BINS-1 (bin 0 when r is zero), one
// quotient bit per cycle by restoring division. Depends on hms_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hms_bin_div (
    input  logic              clk,
    input  logic              rst_n,
    input  hms_pkg::div_req_t req,
    output hms_pkg::div_rsp_t rsp
);

    localparam int CW = $clog2(hms_pkg::BIN_W + 1);

    logic                        busy_reg;
    logic [CW-1:0]               cnt_reg;
    logic [hms_pkg::PIX_W:0]     rem_reg;
    logic [hms_pkg::PIX_W-1:0]   dvs_reg;
    logic [hms_pkg::BIN_W-1:0]   q_reg;
    logic                        ovf_reg;
    logic                        done_reg;
    logic [hms_pkg::BIN_W-1:0]   bin_reg;

    logic [hms_pkg::PIX_W:0]     rem_dbl;
    logic                        ge;
    logic [hms_pkg::BIN_W-1:0]   q_next;

    // one restoring step
    assign rem_dbl = {rem_reg[hms_pkg::PIX_W-1:0], 1'b0};
    assign ge      = rem_dbl >= {1'b0, dvs_reg};
    assign q_next  = {q_reg[hms_pkg::BIN_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            q_reg    <= '0;
            ovf_reg  <= 1'b0;
            done_reg <= 1'b0;
            bin_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                // zero range: everything lands in bin 0
                if (req.divisor == '0)
                begin
                    done_reg <= 1'b1;
                    bin_reg  <= '0;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CW'(hms_pkg::BIN_W);
                    dvs_reg  <= req.divisor;
                    q_reg    <= '0;
                    // top quotient bit set when d is at least r
                    ovf_reg  <= req.dividend >= req.divisor;
                    rem_reg  <= (req.dividend >= req.divisor)
                                ? {1'b0, req.dividend - req.divisor}
                                : {1'b0, req.dividend};
                end
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? rem_dbl - {1'b0, dvs_reg} : rem_dbl;
                q_reg   <= q_next;
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    bin_reg  <= ovf_reg ? '1 : q_next;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.bin  = bin_reg;

    `CHK_NEXT(a_start_runs, req.start, busy_reg || done_reg, "divider did not start")
    `CHK_IMPLY(a_done_idle, done_reg, !busy_reg, "divider done while busy")

endmodule

[rtl/core/histogram_mode_subtract.sv]
// Histogram mode background subtraction over one image.
// Channels: item (operation, pixel) in, result (value, kind, last) out, both
// valid/ready; a transfer happens when valid and ready are high at a clock edge.
// Configuration: cfg_we/cfg_index/cfg_data set image_width and image_height.
// A load stores the pixel. The last load of an image starts
// the mode search: a bin clear, a walk over the region pixels for min/max, a
// histogram pass over the region pixels (bin divider of 8 steps plus the
// bin read-modify-write), a bin scan, and forming and presenting the mode,
// which is reported with kind 0.
// A drain reads the pixel memory and returns the stored pixel minus the
// mode, saturated, with last set on the final pixel.
// One item is in work at a time. Input is taken only when the block is idle
// and the output register is empty or being emptied in the same cycle, so a
// stalled receiver holding a result also holds off the next input transfer.
// Reset clears counters and the mode and sets both dimensions to 1024;
// the pixel memory is not cleared.
// Depends on hms_pkg, hms_if, hms_ram, hms_bin_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module histogram_mode_subtract #(
    parameter int MAX_PIXELS = hms_pkg::MAX_PIXELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hms_pkg::DIM_W-1:0]       cfg_data,
    hms_item_if.sink                        item,
    hms_result_if.source                    result
);

    localparam int AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int PW  = hms_pkg::PIX_W;
    localparam int DW  = hms_pkg::DIM_W;
    localparam int CW  = hms_pkg::CNT_W;
    localparam int BW  = hms_pkg::BIN_W;
    localparam int PDW = hms_pkg::DIV10_PW;

    typedef enum logic [3:0] {
        S_IDLE, S_DRAIN, S_CLR, S_MM, S_MM_END, S_H_RD, S_H_DAT, S_H_DIV,
        S_H_BRD, S_H_BWR, S_SCAN, S_SCAN_END, S_MODE1, S_MODE2, S_OUT
    } state_t;

    state_t                 st_reg;
    logic [DW-1:0]          width_reg, height_reg;
    logic [CW-1:0]          load_cnt_reg, drain_cnt_reg;
    logic                   fin_reg;
    logic [DW-1:0]          wx_reg, wy_reg;
    logic [CW-1:0]          row_reg;
    logic                   rd_oob_reg;
    logic                   mm_vld_reg, first_reg;
    logic signed [PW-1:0]   min_reg, max_reg, mode_reg;
    logic [BW-1:0]          idx_reg, scan_q_reg, hbin_reg, best_reg;
    logic                   scan_vld_reg;
    logic [CW-1:0]          best_cnt_reg;
    logic [PW+BW-1:0]       prod_reg;
    logic                   rvalid_reg;
    logic signed [PW-1:0]   rvalue_reg;
    logic                   rkind_reg, rlast_reg;

    logic [DW-1:0]          w_c, h_c, xm, ym, x_end, y_end;
    logic [PDW-1:0]         w_sc, h_sc;
    logic [2*DW-1:0]        area, row0_full;
    logic [CW-1:0]          total, walk_addr, load_inc;
    logic                   walk_last, accept, out_free, res_load;
    logic                   pix_we, oob_next;
    logic [AW-1:0]          pix_raddr;
    logic [PW-1:0]          pix_rdata;
    logic signed [PW-1:0]   pix_val;
    logic [PW-1:0]          range_u;
    logic                   bin_we;
    logic [BW-1:0]          bin_waddr, bin_raddr;
    logic [CW-1:0]          bin_wdata, bin_rdata;
    logic [PW:0]            diff;
    logic signed [PW-1:0]   sat_val;
    hms_pkg::div_req_t      div_req;
    hms_pkg::div_rsp_t      div_rsp;

    // clamped dimensions, margins and pixel count
    assign w_c = (width_reg == '0) ? DW'(1)
               : ((width_reg > DW'(hms_pkg::DIM_MAX)) ? DW'(hms_pkg::DIM_MAX) : width_reg);
    assign h_c = (height_reg == '0) ? DW'(1)
               : ((height_reg > DW'(hms_pkg::DIM_MAX)) ? DW'(hms_pkg::DIM_MAX) : height_reg);
    assign w_sc  = PDW'(w_c) * PDW'(hms_pkg::DIV10_MUL);
    assign h_sc  = PDW'(h_c) * PDW'(hms_pkg::DIV10_MUL);
    assign xm    = DW'(w_sc >> hms_pkg::DIV10_SHIFT);
    assign ym    = DW'(h_sc >> hms_pkg::DIV10_SHIFT);
    assign x_end = w_c - xm - DW'(1);
    assign y_end = h_c - ym - DW'(1);
    assign area      = {{DW{1'b0}}, w_c} * {{DW{1'b0}}, h_c};
    assign row0_full = {{DW{1'b0}}, ym} * {{DW{1'b0}}, w_c};
    assign total     = CW'(area);

    // region walker address
    assign walk_addr = row_reg + CW'(wx_reg);
    assign walk_last = (wx_reg == x_end) && (wy_reg == y_end);

    // handshakes
    assign out_free   = !rvalid_reg || result.ready;
    assign item.ready = (st_reg == S_IDLE) && out_free;
    assign accept     = item.valid && item.ready;
    assign load_inc   = load_cnt_reg + CW'(1);
    assign res_load   = ((st_reg == S_DRAIN) || (st_reg == S_OUT)) && out_free;

    // pixel store ports
    assign pix_we    = accept && (item.operation == hms_pkg::OP_LOAD)
                       && (32'(load_cnt_reg) < MAX_PIXELS);
    assign pix_raddr = (st_reg == S_IDLE) ? AW'(drain_cnt_reg) : AW'(walk_addr);
    assign oob_next  = (st_reg == S_IDLE) ? (32'(drain_cnt_reg) >= MAX_PIXELS)
                                          : (32'(walk_addr) >= MAX_PIXELS);
    assign pix_val   = rd_oob_reg ? '0 : $signed(pix_rdata);

    hms_ram #(.WIDTH(PW), .DEPTH(MAX_PIXELS)) u_pix_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (AW'(load_cnt_reg)),
        .wdata (item.pixel),
        .raddr (pix_raddr),
        .rdata (pix_rdata)
    );

    // bin count store: clear sweep, increment, scan
    assign bin_we    = (st_reg == S_CLR) || (st_reg == S_H_BWR);
    assign bin_waddr = (st_reg == S_CLR) ? idx_reg : hbin_reg;
    assign bin_wdata = (st_reg == S_CLR) ? '0 : bin_rdata + CW'(1);
    assign bin_raddr = (st_reg == S_SCAN) ? idx_reg : hbin_reg;

    hms_ram #(.WIDTH(CW), .DEPTH(hms_pkg::NUM_BINS)) u_bin_ram (
        .clk   (clk),
        .we    (bin_we),
        .waddr (bin_waddr),
        .wdata (bin_wdata),
        .raddr (bin_raddr),
        .rdata (bin_rdata)
    );

    // bin index of the pixel just read
    assign range_u          = max_reg - min_reg;
    assign div_req.start    = (st_reg == S_H_DAT);
    assign div_req.dividend = pix_val - min_reg;
    assign div_req.divisor  = range_u;

    hms_bin_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // saturating pixel minus mode
    assign diff    = {pix_val[PW-1], pix_val} - {mode_reg[PW-1], mode_reg};
    assign sat_val = (diff[PW] != diff[PW-1])
                     ? (diff[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}})
                     : $signed(diff[PW-1:0]);

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            width_reg     <= DW'(hms_pkg::DIM_MAX);
            height_reg    <= DW'(hms_pkg::DIM_MAX);
            load_cnt_reg  <= '0;
            drain_cnt_reg <= '0;
            fin_reg       <= 1'b0;
            wx_reg        <= '0;
            wy_reg        <= '0;
            row_reg       <= '0;
            rd_oob_reg    <= 1'b0;
            mm_vld_reg    <= 1'b0;
            first_reg     <= 1'b0;
            min_reg       <= '0;
            max_reg       <= '0;
            mode_reg      <= '0;
            idx_reg       <= '0;
            scan_q_reg    <= '0;
            hbin_reg      <= '0;
            best_reg      <= '0;
            scan_vld_reg  <= 1'b0;
            best_cnt_reg  <= '0;
            prod_reg      <= '0;
            rvalid_reg    <= 1'b0;
            rvalue_reg    <= '0;
            rkind_reg     <= 1'b0;
            rlast_reg     <= 1'b0;
        end
        else
        begin
            rd_oob_reg   <= oob_next;
            mm_vld_reg   <= (st_reg == S_MM);
            scan_vld_reg <= (st_reg == S_SCAN);

            // output register valid: a new result wins over the drain of the old one
            if (res_load)
            begin
                rvalid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                rvalid_reg <= 1'b0;
            end

            // region min/max from the pixel read in the previous cycle
            if (mm_vld_reg)
            begin
                first_reg <= 1'b0;
                if (first_reg || (pix_val < min_reg))
                begin
                    min_reg <= pix_val;
                end
                if (first_reg || (pix_val > max_reg))
                begin
                    max_reg <= pix_val;
                end
            end

            // first highest bin wins
            if (scan_vld_reg && (bin_rdata > best_cnt_reg))
            begin
                best_cnt_reg <= bin_rdata;
                best_reg     <= scan_q_reg;
            end

            unique case (st_reg)
                S_IDLE:
                begin
                    if (cfg_we)
                    begin
                        unique case (hms_pkg::cfg_reg_t'(cfg_index))
                            hms_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                            hms_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                            default: ;
                        endcase
                        load_cnt_reg  <= '0;
                        drain_cnt_reg <= '0;
                    end
                    else if (accept)
                    begin
                        if (item.operation == hms_pkg::OP_DRAIN)
                        begin
                            fin_reg       <= (drain_cnt_reg + CW'(1)) >= total;
                            drain_cnt_reg <= ((drain_cnt_reg + CW'(1)) >= total)
                                             ? '0 : drain_cnt_reg + CW'(1);
                            st_reg        <= S_DRAIN;
                        end
                        else if (load_inc >= total)
                        begin
                            load_cnt_reg  <= '0;
                            drain_cnt_reg <= '0;
                            idx_reg       <= '0;
                            st_reg        <= S_CLR;
                        end
                        else
                        begin
                            load_cnt_reg <= load_inc;
                        end
                    end
                end
                S_DRAIN:
                begin
                    if (out_free)
                    begin
                        rvalue_reg <= sat_val;
                        rkind_reg  <= hms_pkg::KIND_PIXEL;
                        rlast_reg  <= fin_reg;
                        st_reg     <= S_IDLE;
                    end
                end
                S_CLR:
                begin
                    idx_reg <= idx_reg + BW'(1);
                    if (idx_reg == '1)
                    begin
                        wx_reg    <= xm;
                        wy_reg    <= ym;
                        row_reg   <= CW'(row0_full);
                        first_reg <= 1'b1;
                        st_reg    <= S_MM;
                    end
                end
                S_MM:
                begin
                    if (walk_last)
                    begin
                        st_reg <= S_MM_END;
                    end
                    else if (wx_reg == x_end)
                    begin
                        wx_reg  <= xm;
                        wy_reg  <= wy_reg + DW'(1);
                        row_reg <= row_reg + CW'(w_c);
                    end
                    else
                    begin
                        wx_reg <= wx_reg + DW'(1);
                    end
                end
                S_MM_END:
                begin
                    wx_reg  <= xm;
                    wy_reg  <= ym;
                    row_reg <= CW'(row0_full);
                    st_reg  <= S_H_RD;
                end
                S_H_RD:
                begin
                    st_reg <= S_H_DAT;
                end
                S_H_DAT:
                begin
                    st_reg <= S_H_DIV;
                end
                S_H_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        hbin_reg <= div_rsp.bin;
                        st_reg   <= S_H_BRD;
                    end
                end
                S_H_BRD:
                begin
                    st_reg <= S_H_BWR;
                end
                S_H_BWR:
                begin
                    if (walk_last)
                    begin
                        idx_reg      <= '0;
                        best_reg     <= '0;
                        best_cnt_reg <= '0;
                        st_reg       <= S_SCAN;
                    end
                    else
                    begin
                        if (wx_reg == x_end)
                        begin
                            wx_reg  <= xm;
                            wy_reg  <= wy_reg + DW'(1);
                            row_reg <= row_reg + CW'(w_c);
                        end
                        else
                        begin
                            wx_reg <= wx_reg + DW'(1);
                        end
                        st_reg <= S_H_RD;
                    end
                end
                S_SCAN:
                begin
                    scan_q_reg <= idx_reg;
                    idx_reg    <= idx_reg + BW'(1);
                    if (idx_reg == '1)
                    begin
                        st_reg <= S_SCAN_END;
                    end
                end
                S_SCAN_END:
                begin
                    st_reg <= S_MODE1;
                end
                S_MODE1:
                begin
                    prod_reg <= (PW+BW)'(best_reg) * (PW+BW)'(range_u);
                    st_reg   <= S_MODE2;
                end
                S_MODE2:
                begin
                    mode_reg <= min_reg + $signed(PW'(prod_reg >> BW));
                    st_reg   <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        rvalue_reg <= mode_reg;
                        rkind_reg  <= hms_pkg::KIND_MODE;
                        rlast_reg  <= 1'b0;
                        st_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid = rvalid_reg;
    assign result.value = rvalue_reg;
    assign result.kind  = rkind_reg;
    assign result.last  = rlast_reg;

    `CHK_IMPLY(a_bwr_after_brd, st_reg == S_H_BWR, $past(st_reg) == S_H_BRD, "bin write without read")
    `CHK_IMPLY(a_mode_not_last, result.valid && (result.kind == hms_pkg::KIND_MODE), !result.last, "mode report flagged last")
    `CHK_IMPLY(a_walk_in_image, (st_reg == S_MM) || (st_reg == S_H_RD), walk_addr < total, "region walk left the image")

endmodule
